// File: rtl/ncs_pkg.sv
// Shared types and constants for the next coprime candidate sieve.
// Holds the built-in prime table, lane command types and the state encoding.
// No dependencies.
package ncs_pkg;

	localparam int NUM_PRIMES = 64;
	localparam int PRIME_W    = 9;
	localparam int CAND_W     = 128;
	localparam int HALF_W     = 64;
	localparam int GAP_W      = 20;
	localparam int BIT_CNT_W  = $clog2(CAND_W);

	localparam logic [GAP_W-1:0] GAP_MAX = {GAP_W{1'b1}};

	typedef logic [PRIME_W-1:0] prime_t;

	localparam prime_t PRIMES [NUM_PRIMES] = '{
		9'd2,   9'd3,   9'd5,   9'd7,   9'd11,  9'd13,  9'd17,  9'd19,
		9'd23,  9'd29,  9'd31,  9'd37,  9'd41,  9'd43,  9'd47,  9'd53,
		9'd59,  9'd61,  9'd67,  9'd71,  9'd73,  9'd79,  9'd83,  9'd89,
		9'd97,  9'd101, 9'd103, 9'd107, 9'd109, 9'd113, 9'd127, 9'd131,
		9'd137, 9'd139, 9'd149, 9'd151, 9'd157, 9'd163, 9'd167, 9'd173,
		9'd179, 9'd181, 9'd191, 9'd193, 9'd197, 9'd199, 9'd211, 9'd223,
		9'd227, 9'd229, 9'd233, 9'd239, 9'd241, 9'd251, 9'd257, 9'd263,
		9'd269, 9'd271, 9'd277, 9'd281, 9'd283, 9'd293, 9'd307, 9'd311
	};

	typedef enum logic {
		OP_LOAD    = 1'b0,
		OP_ADVANCE = 1'b1
	} opcode_t;

	typedef enum logic [2:0] {
		LANE_HOLD,
		LANE_CLEAR,
		LANE_SHIFT,
		LANE_INIT,
		LANE_STEP,
		LANE_COMMIT
	} lane_op_t;

	typedef struct packed {
		lane_op_t op;
		logic     din;
	} lane_cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOAD,
		ST_SEARCH,
		ST_ADD,
		ST_DONE
	} state_t;

endpackage

// File: rtl/ncs_lane.sv
// One residue lane: keeps the candidate modulo one prime and a trial residue.
// Depends on ncs_pkg for the command struct and widths.
module ncs_lane (
	input  logic              clk,
	input  logic              arst_n,
	input  ncs_pkg::prime_t   prime,
	input  ncs_pkg::lane_cmd_t cmd,
	output logic              zero
);
	import ncs_pkg::*;

	prime_t             res_q;
	prime_t             try_q;
	prime_t             res_d;
	prime_t             try_d;
	logic [PRIME_W:0]   dbl;
	logic [PRIME_W:0]   res_inc;
	logic [PRIME_W:0]   try_inc;

	assign dbl     = {res_q, cmd.din};
	assign res_inc = {1'b0, res_q} + {{PRIME_W{1'b0}}, 1'b1};
	assign try_inc = {1'b0, try_q} + {{PRIME_W{1'b0}}, 1'b1};
	assign zero    = (try_q == '0);

	always_comb begin
		res_d = res_q;
		try_d = try_q;
		unique case (cmd.op)
			LANE_HOLD: begin
			end
			LANE_CLEAR: begin
				res_d = '0;
			end
			LANE_SHIFT: begin
				// Doubled residue plus one bit stays below twice the prime.
				if (dbl >= {1'b0, prime})
					res_d = PRIME_W'(dbl - {1'b0, prime});
				else
					res_d = dbl[PRIME_W-1:0];
			end
			LANE_INIT: begin
				try_d = (res_inc == {1'b0, prime}) ? '0 : res_inc[PRIME_W-1:0];
			end
			LANE_STEP: begin
				try_d = (try_inc == {1'b0, prime}) ? '0 : try_inc[PRIME_W-1:0];
			end
			LANE_COMMIT: begin
				res_d = try_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_q <= '0;
		end else begin
			res_q <= res_d;
		end
	end

	always_ff @(posedge clk) begin
		try_q <= try_d;
	end

endmodule

// File: rtl/next_coprime_candidate_sieve_top.sv
// Load: one transfer in, the candidate shifted MSB first through 64 residue
// lanes, then the result. Advance: one trial gap per cycle across all lanes,
// then one 128-bit add once a gap leaves no lane at zero. One item is in
// flight at a time; s_tready is low meanwhile.
// Reset clears the candidate and every residue to zero and leaves the block idle.
module next_coprime_candidate_sieve_top (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	input  logic [127:0] s_tdata,   // value_high [63:0], value_low [127:64]
	input  logic         s_tuser,   // opcode [0]
	output logic         m_tvalid,
	input  logic         m_tready,
	output logic [151:0] m_tdata,   // gap [19:0], candidate_high [83:20],
	                                // candidate_low [147:84], zero fill above
	output logic         m_tuser    // status [0]
);
	import ncs_pkg::*;

	state_t                state_q;
	state_t                state_d;
	lane_cmd_t             cmd;
	logic [NUM_PRIMES-1:0] zero_vec;
	logic                  any_zero;
	logic                  out_free;
	logic                  accept;

	logic [CAND_W-1:0]     cand_q;
	logic [CAND_W-1:0]     shift_q;
	logic [BIT_CNT_W-1:0]  cnt_q;
	logic [GAP_W-1:0]      gap_q;
	logic [GAP_W-1:0]      gap_res_q;
	logic                  status_q;
	logic [CAND_W:0]       sum;

	// The candidate is held as {high, low}; the input carries high in the low bits.
	assign s_tready = (state_q == ST_IDLE);
	assign accept   = s_tvalid && s_tready;
	assign any_zero = |zero_vec;
	assign out_free = !m_tvalid || m_tready;
	assign sum      = {1'b0, cand_q} + {{(CAND_W + 1 - GAP_W){1'b0}}, gap_q};

	// Each lane owns one prime of the table and reports when the trial gap
	// would make the candidate divisible by that prime.
	for (genvar i = 0; i < NUM_PRIMES; i++) begin : g_lane
		ncs_lane u_lane (
			.clk    (clk),
			.arst_n (arst_n),
			.prime  (PRIMES[i]),
			.cmd    (cmd),
			.zero   (zero_vec[i])
		);
	end

	always_comb begin
		state_d = state_q;
		cmd.op  = LANE_HOLD;
		cmd.din = shift_q[CAND_W-1];
		unique case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					if (s_tuser == OP_LOAD) begin
						cmd.op  = LANE_CLEAR;
						state_d = ST_LOAD;
					end else begin
						// Trial residues start at residue + 1 for a gap of one.
						cmd.op  = LANE_INIT;
						state_d = ST_SEARCH;
					end
				end
			end
			ST_LOAD: begin
				cmd.op = LANE_SHIFT;
				if (cnt_q == '0)
					state_d = ST_DONE;
			end
			ST_SEARCH: begin
				// A lane at zero means the current gap hits a divisor.
				if (!any_zero)
					state_d = ST_ADD;
				else if (gap_q == GAP_MAX)
					state_d = ST_DONE;
				else
					cmd.op = LANE_STEP;
			end
			ST_ADD: begin
				// Residues move on only when the candidate does.
				if (!sum[CAND_W])
					cmd.op = LANE_COMMIT;
				state_d = ST_DONE;
			end
			ST_DONE: begin
				if (out_free)
					state_d = ST_IDLE;
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			m_tvalid <= 1'b0;
			cand_q   <= '0;
		end else begin
			state_q <= state_d;
			if (m_tvalid && m_tready)
				m_tvalid <= 1'b0;
			if (state_q == ST_DONE && out_free)
				m_tvalid <= 1'b1;
			if (accept && s_tuser == OP_LOAD)
				cand_q <= {s_tdata[HALF_W-1:0], s_tdata[CAND_W-1:HALF_W]};
			if (state_q == ST_ADD && !sum[CAND_W])
				cand_q <= sum[CAND_W-1:0];
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (accept) begin
					shift_q   <= {s_tdata[HALF_W-1:0], s_tdata[CAND_W-1:HALF_W]};
					cnt_q     <= {BIT_CNT_W{1'b1}};
					gap_q     <= {{(GAP_W-1){1'b0}}, 1'b1};
					status_q  <= 1'b0;
					gap_res_q <= '0;
				end
			end
			ST_LOAD: begin
				shift_q <= {shift_q[CAND_W-2:0], 1'b0};
				cnt_q   <= cnt_q - 1'b1;
			end
			ST_SEARCH: begin
				if (any_zero) begin
					if (gap_q == GAP_MAX) begin
						// No usable gap in range: report like an overflow.
						status_q  <= 1'b1;
						gap_res_q <= '0;
					end else begin
						gap_q <= gap_q + 1'b1;
					end
				end
			end
			ST_ADD: begin
				if (sum[CAND_W]) begin
					status_q  <= 1'b1;
					gap_res_q <= '0;
				end else begin
					status_q  <= 1'b0;
					gap_res_q <= gap_q;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					m_tdata <= {4'b0, cand_q[HALF_W-1:0], cand_q[CAND_W-1:HALF_W],
						gap_res_q};
					m_tuser <= status_q;
				end
			end
			default: begin
			end
		endcase
	end

endmodule
